### rtl/core/u8sf_pkg.sv
package u8sf_pkg;

    localparam int unsigned BURST_MAX = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_DISCARD = 2'd2
    } t_mode;

    // Scan state carried from one byte to the next.
    typedef struct packed {
        t_mode      mode;
        logic [1:0] need;
        logic [1:0] coll;
    } t_scan;

    // Results caused by one input byte, oldest in entry 0.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      bare;
        logic                      eos;
    } t_burst;

    // Write port into the held sequence bytes.
    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] data;
    } t_pend_wr;

    // Printable ASCII passes, as do the five layout controls.
    function automatic logic keep_ascii(input logic [7:0] b);
        logic ctrl;
        ctrl = (b <= 8'h1F) || (b == 8'h7F);
        keep_ascii = !ctrl || (b inside {8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D});
    endfunction

endpackage

### rtl/core/utf8_sanitize_filter.sv
// UTF-8 sanitizing byte filter.
// Input channel: i_valid / o_stall with i_data_byte and i_end_of_string; a
// transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_out_byte, o_byte_valid,
// o_string_end and o_last_of_run; one result per transfer.
// Each input byte yields zero to four results. A completed multi-byte
// sequence comes out as a run of two to four consecutive results; a byte
// with the end mark always yields at least a bare end marker.
// The byte sits in the input register, is decoded into the result register
// and is offered from there. Throughput is one input byte per cycle while
// each byte yields at most one result and the receiver does not stall; the
// result register drains one result per cycle while the receiver does not
// stall, so a run of results holds the input register until all are taken.
// When the receiver stalls, the current result holds steady, the input
// register fills and o_stall rises. Reset clears the scan state, the input
// register and the result register; held sequence bytes need no reset.
module utf8_sanitize_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_string_end,
    output logic        o_last_of_run
);

    logic                  r_in_vld;
    logic [7:0]            r_in_byte;
    logic                  r_in_eos;
    u8sf_pkg::t_scan       r_scan;
    u8sf_pkg::t_scan       n_scan;
    logic [2:0][7:0]       r_pend;
    u8sf_pkg::t_pend_wr    pend_wr;
    u8sf_pkg::t_burst      burst;
    logic                  can_load;
    logic                  move;
    logic                  accept;

    assign move    = r_in_vld && can_load;
    assign o_stall = r_in_vld && !can_load;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '{mode: u8sf_pkg::MODE_NORMAL, need: 2'd0, coll: 2'd0};
        end else if (move) begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && pend_wr.we) begin
            r_pend[pend_wr.idx] <= pend_wr.data;
        end
    end

    u8sf_decode u_decode (
        .i_scan    (r_scan),
        .i_pend    (r_pend),
        .i_byte    (r_in_byte),
        .i_eos     (r_in_eos),
        .o_scan    (n_scan),
        .o_pend_wr (pend_wr),
        .o_burst   (burst)
    );

    u8sf_burst u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (move),
        .i_burst       (burst),
        .i_stall       (i_stall),
        .o_can_load    (can_load),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_string_end  (o_string_end),
        .o_last_of_run (o_last_of_run)
    );

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan.mode != u8sf_pkg::MODE_COLLECT |-> r_scan.need == 2'd0 && r_scan.coll == 2'd0)
        else $error("sequence counters set outside collection");

    a_collect_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan.mode == u8sf_pkg::MODE_COLLECT |->
            r_scan.coll != 2'd0 && r_scan.need != 2'd0 &&
            ({1'b0, r_scan.coll} + {1'b0, r_scan.need}) >= 3'd2 &&
            ({1'b0, r_scan.coll} + {1'b0, r_scan.need}) <= 3'd4)
        else $error("collected and awaited bytes do not form a sequence");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_eos) |=> r_scan.mode == u8sf_pkg::MODE_NORMAL && r_scan.coll == 2'd0)
        else $error("scan state survived the end of the string");

endmodule

### rtl/core/u8sf_decode.sv
module u8sf_decode (
    input  u8sf_pkg::t_scan         i_scan,
    input  logic [2:0][7:0]         i_pend,
    input  logic [7:0]              i_byte,
    input  logic                    i_eos,
    output u8sf_pkg::t_scan         o_scan,
    output u8sf_pkg::t_pend_wr      o_pend_wr,
    output u8sf_pkg::t_burst        o_burst
);

    // Next scan state and the write into the held sequence bytes.
    always_comb begin
        o_scan    = i_scan;
        o_pend_wr = '0;

        case (i_scan.mode)
            u8sf_pkg::MODE_COLLECT: begin
                if (i_byte[7:6] == 2'b10) begin
                    if (i_scan.need <= 2'd1) begin
                        o_scan.mode = u8sf_pkg::MODE_NORMAL;
                        o_scan.need = 2'd0;
                        o_scan.coll = 2'd0;
                    end else begin
                        if (i_scan.coll < 2'd3) begin
                            o_pend_wr.we   = 1'b1;
                            o_pend_wr.idx  = i_scan.coll;
                            o_pend_wr.data = i_byte;
                            o_scan.coll    = i_scan.coll + 2'd1;
                        end
                        o_scan.need = i_scan.need - 2'd1;
                    end
                end else if (!i_byte[7]) begin
                    o_scan.mode = u8sf_pkg::MODE_NORMAL;
                    o_scan.need = 2'd0;
                    o_scan.coll = 2'd0;
                end else begin
                    o_scan.mode = u8sf_pkg::MODE_DISCARD;
                    o_scan.need = 2'd0;
                    o_scan.coll = 2'd0;
                end
            end
            u8sf_pkg::MODE_DISCARD: begin
                if (!i_byte[7]) begin
                    o_scan.mode = u8sf_pkg::MODE_NORMAL;
                end
            end
            default: begin
                o_scan.mode = u8sf_pkg::MODE_NORMAL;
                if (!i_byte[7]) begin
                    o_scan.mode = u8sf_pkg::MODE_NORMAL;
                end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110 ||
                             i_byte[7:3] == 5'b11110) begin
                    if (i_byte[7:5] == 3'b110) begin
                        o_scan.need = 2'd1;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        o_scan.need = 2'd2;
                    end else begin
                        o_scan.need = 2'd3;
                    end
                    o_pend_wr.we   = 1'b1;
                    o_pend_wr.idx  = 2'd0;
                    o_pend_wr.data = i_byte;
                    o_scan.coll    = 2'd1;
                    o_scan.mode    = u8sf_pkg::MODE_COLLECT;
                end else begin
                    o_scan.mode = u8sf_pkg::MODE_DISCARD;
                end
            end
        endcase

        if (i_eos) begin
            // The end of the string drops any sequence still being collected.
            o_scan.mode = u8sf_pkg::MODE_NORMAL;
            o_scan.need = 2'd0;
            o_scan.coll = 2'd0;
        end
    end

    // Results caused by the byte.
    always_comb begin
        o_burst     = '0;
        o_burst.eos = i_eos;

        case (i_scan.mode)
            u8sf_pkg::MODE_COLLECT: begin
                if (i_byte[7:6] == 2'b10) begin
                    if (i_scan.need <= 2'd1) begin
                        // Sequence complete: flush the held bytes and this one.
                        for (int k = 0; k < 3; k++) begin
                            if (2'(k) < i_scan.coll) begin
                                o_burst.bytes[k] = i_pend[k];
                            end
                        end
                        o_burst.bytes[i_scan.coll] = i_byte;
                        o_burst.cnt = {1'b0, i_scan.coll} + 3'd1;
                    end
                end else if (!i_byte[7] && u8sf_pkg::keep_ascii(i_byte)) begin
                    o_burst.bytes[0] = i_byte;
                    o_burst.cnt      = 3'd1;
                end
            end
            default: begin
                // An ASCII byte ends a discard run and is handled as in normal mode.
                if (!i_byte[7] && u8sf_pkg::keep_ascii(i_byte)) begin
                    o_burst.bytes[0] = i_byte;
                    o_burst.cnt      = 3'd1;
                end
            end
        endcase

        if (i_eos && o_burst.cnt == 3'd0) begin
            o_burst.cnt  = 3'd1;
            o_burst.bare = 1'b1;
        end
    end

endmodule

### rtl/core/u8sf_burst.sv
module u8sf_burst (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u8sf_pkg::t_burst    i_burst,
    input  logic                i_stall,
    output logic                o_can_load,
    output logic                o_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_string_end,
    output logic                o_last_of_run
);

    logic [u8sf_pkg::BURST_MAX-1:0][7:0] r_bytes;
    logic [2:0]                          r_cnt;
    logic                                r_bare;
    logic                                r_eos;
    logic                                take;

    assign o_valid       = (r_cnt != 3'd0);
    assign take          = o_valid && !i_stall;
    assign o_can_load    = (r_cnt == 3'd0) || (r_cnt == 3'd1 && take);
    assign o_out_byte    = r_bytes[0];
    assign o_byte_valid  = !r_bare;
    assign o_last_of_run = (r_cnt == 3'd1);
    assign o_string_end  = o_last_of_run && r_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // Each transfer shifts the next result of the run down to entry 0.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_bare  <= i_burst.bare;
            r_eos   <= i_burst.eos;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[u8sf_pkg::BURST_MAX-1:1]};
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == 3'd0) || (r_cnt == 3'd1 && take))
        else $error("burst loaded over undelivered results");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(u8sf_pkg::BURST_MAX))
        else $error("burst count out of range");

    a_bare_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last_of_run && o_string_end)
        else $error("bare end marker not alone at end of string");

endmodule

### verif/utf8_filter_checker.sv
`timescale 1ns / 1ps

module utf8_filter_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_src_valid,
    input  logic       i_src_stall,
    input  logic [7:0] i_src_byte,
    input  logic       i_src_eos,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_res_byte,
    input  logic       i_res_byte_valid,
    input  logic       i_res_string_end,
    input  logic       i_res_last,
    output int         o_fail_count,
    output int         o_expect_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       kept;
        logic       str_end;
        logic       last;
    } t_filt_result;

    t_filt_result awaited[$];
    t_filt_result burst[$];

    u8sf_pkg::t_mode scan_mode;
    logic [1:0]      cont_left;
    logic [1:0]      held_cnt;
    logic [7:0]      held [3];
    int              fail_cnt = 0;
    int              result_idx = 0;

    function automatic bit ascii_kept(input logic [7:0] b);
        if (b == 8'h7F) return 1'b0;
        if (b >= 8'h20) return 1'b1;
        return b == 8'h08 || b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic kept);
        t_filt_result r;
        r = '{data: b, kept: kept, str_end: 1'b0, last: 1'b0};
        burst = {burst, r};
    endtask

    task automatic push_kept(input logic [7:0] b);
        add_result(b, 1'b1);
    endtask

    task automatic take_ascii(input logic [7:0] b);
        if (ascii_kept(b)) push_kept(b);
    endtask

    task automatic drop_held();
        scan_mode = u8sf_pkg::MODE_NORMAL;
        cont_left = 2'd0;
        held_cnt  = 2'd0;
    endtask

    // Works out every result that one accepted byte causes, in order.
    task automatic scan_byte(input logic [7:0] b, input logic eos);
        int         k;
        logic [1:0] lead;
        burst.delete();
        case (scan_mode)
            u8sf_pkg::MODE_COLLECT: begin
                if (b[7:6] == 2'b10) begin
                    if (cont_left <= 2'd1) begin
                        for (k = 0; k < held_cnt && k < 3; k++) push_kept(held[k]);
                        push_kept(b);
                        drop_held();
                    end else begin
                        if (held_cnt < 2'd3) begin
                            held[held_cnt] = b;
                            held_cnt = held_cnt + 2'd1;
                        end
                        cont_left = cont_left - 2'd1;
                    end
                end else if (!b[7]) begin
                    drop_held();
                    take_ascii(b);
                end else begin
                    drop_held();
                    scan_mode = u8sf_pkg::MODE_DISCARD;
                end
            end
            u8sf_pkg::MODE_DISCARD: begin
                if (!b[7]) begin
                    scan_mode = u8sf_pkg::MODE_NORMAL;
                    take_ascii(b);
                end
            end
            default: begin
                scan_mode = u8sf_pkg::MODE_NORMAL;
                if (!b[7]) begin
                    take_ascii(b);
                end else begin
                    casez (b)
                        8'b110?????: lead = 2'd1;
                        8'b1110????: lead = 2'd2;
                        8'b11110???: lead = 2'd3;
                        default:     lead = 2'd0;
                    endcase
                    if (lead == 2'd0) begin
                        scan_mode = u8sf_pkg::MODE_DISCARD;
                    end else begin
                        cont_left = lead;
                        held[0]   = b;
                        held_cnt  = 2'd1;
                        scan_mode = u8sf_pkg::MODE_COLLECT;
                    end
                end
            end
        endcase
        // The end mark discards a half-collected sequence and always yields something.
        if (eos) begin
            drop_held();
            if (burst.size() == 0)
                add_result(8'h00, 1'b0);
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last    = 1'b1;
            burst[burst.size() - 1].str_end = eos;
        end
        awaited = {awaited, burst};
    endtask

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_result();
        t_filt_result want;
        string        bad;
        if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %0d (byte %02h) with nothing awaited",
                                      result_idx, i_res_byte));
            result_idx++;
            return;
        end
        want = awaited.pop_front();
        bad  = "";
        if (i_res_byte !== want.data)          bad = {bad, " out_byte"};
        if (i_res_byte_valid !== want.kept)    bad = {bad, " byte_valid"};
        if (i_res_string_end !== want.str_end) bad = {bad, " string_end"};
        if (i_res_last !== want.last)          bad = {bad, " last_of_run"};
        if (bad != "")
            report_mismatch($sformatf(
                "result %0d wrong:%s; got %02h/%0b/%0b/%0b, want %02h/%0b/%0b/%0b",
                result_idx, bad, i_res_byte, i_res_byte_valid, i_res_string_end,
                i_res_last, want.data, want.kept, want.str_end, want.last));
        result_idx++;
    endtask

    // Results are checked before the byte of the same edge is scanned, since no
    // byte can produce a result in the cycle of its own transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited.delete();
            drop_held();
        end else begin
            if (i_res_valid && !i_res_stall) compare_result();
            if (i_src_valid && !i_src_stall) scan_byte(i_src_byte, i_src_eos);
        end
        o_fail_count   <= fail_cnt;
        o_expect_count <= awaited.size();
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 50000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    logic [7:0] src_byte;
    logic       src_eos;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] res_byte;
    logic       res_byte_valid;
    logic       res_string_end;
    logic       res_last;

    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    int sent = 0;
    int cycles = 0;
    int fails;
    int awaiting;

    // Bit 8 carries the end-of-string mark.
    logic [8:0] opening_text [29] = '{
        9'h000, 9'h008, 9'h009, 9'h00A, 9'h00C, 9'h00D, 9'h01F, 9'h020, 9'h07F,
        9'h0C3, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h0E2, 9'h041,
        9'h0C3, 9'h0F8, 9'h042,
        9'h080, 9'h0FF, 9'h07E,
        9'h0F0, 9'h190,
        9'h100
    };

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    utf8_sanitize_filter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (src_valid),
        .o_stall         (src_stall),
        .i_data_byte     (src_byte),
        .i_end_of_string (src_eos),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_out_byte      (res_byte),
        .o_byte_valid    (res_byte_valid),
        .o_string_end    (res_string_end),
        .o_last_of_run   (res_last)
    );

    utf8_filter_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_src_valid      (src_valid),
        .i_src_stall      (src_stall),
        .i_src_byte       (src_byte),
        .i_src_eos        (src_eos),
        .i_res_valid      (res_valid),
        .i_res_stall      (res_stall),
        .i_res_byte       (res_byte),
        .i_res_byte_valid (res_byte_valid),
        .i_res_string_end (res_string_end),
        .i_res_last       (res_last),
        .o_fail_count     (fails),
        .o_expect_count   (awaiting)
    );

    always @(negedge clk) begin
        res_stall <= stalls_on && ($urandom_range(0, 99) < 37);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** utf8_sanitize_filter: FAILED **");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 37) begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_byte  <= b;
        src_eos   <= eos;
        do @(posedge clk); while (src_stall);
        sent++;
    endtask

    function automatic logic roll_end();
        return $urandom_range(0, 19) == 0;
    endfunction

    function automatic logic [7:0] lead_byte(input int conts);
        case (conts)
            1:       return {3'b110, 5'($urandom)};
            2:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Mostly well-formed characters, with noise and truncated sequences mixed in.
    task automatic send_random_text(input int n_bytes);
        int start;
        int kind;
        int conts;
        int k;
        start = sent;
        while (sent - start < n_bytes) begin
            kind = $urandom_range(0, 9);
            case (kind)
                3: begin
                    k = $urandom_range(0, 32);
                    send_byte((k == 32) ? 8'h7F : 8'(k), roll_end());
                end
                4, 5, 6: begin
                    conts = kind - 3;
                    send_byte(lead_byte(conts), roll_end());
                    for (k = 0; k < conts; k++) send_byte({2'b10, 6'($urandom)}, roll_end());
                end
                7: send_byte(8'($urandom), roll_end());
                8: begin
                    conts = $urandom_range(1, 3);
                    send_byte(lead_byte(conts), roll_end());
                    for (k = 0; k < $urandom_range(0, conts - 1); k++)
                        send_byte({2'b10, 6'($urandom)}, roll_end());
                end
                default: send_byte(8'($urandom_range(8'h20, 8'h7E)), roll_end());
            endcase
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_byte  = 8'h00;
        src_eos   = 1'b0;
        res_stall = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (opening_text[k]) send_byte(opening_text[k][7:0], opening_text[k][8]);
        send_random_text(50);

        // Hold the sender off until the filter has handed over every result.
        @(negedge clk);
        src_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random_text(50);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_random_text(50);

        @(negedge clk);
        src_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0) begin
            $display("** utf8_sanitize_filter: PASSED **");
        end else begin
            $display("** utf8_sanitize_filter: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/u8sf_pkg.sv
rtl/core/u8sf_decode.sv
rtl/core/u8sf_burst.sv
rtl/core/utf8_sanitize_filter.sv
verif/utf8_filter_checker.sv
verif/testbench.sv
